/* rtl/core/pxswc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxswc_pkg
// Shared types, codes and helpers of the pcg xor sbox word cipher.
// ----------------------------------------------------------------------------
package pxswc_pkg;

	// request kind carried on tuser
	typedef enum logic [1:0] {
		FUNC_LOAD_FWD = 2'd0,
		FUNC_LOAD_INV = 2'd1,
		FUNC_ENCRYPT  = 2'd2,
		FUNC_DECRYPT  = 2'd3
	} func_t;

	// configuration register indexes
	localparam logic REG_SEED_LOW  = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	// generator multiplier
	localparam logic [127:0] LCG_MULT = 128'h2360ED051FC65DA4_4385DF649FCCF645;

	// request fields that ride alongside the generator state
	typedef struct packed {
		func_t       func;
		logic [63:0] idx;
		logic [63:0] data;
		logic [7:0]  slot;
		logic [7:0]  tbyte;
		logic [63:0] key1;
	} side_t;

	// xsl-rr output: xor halves, rotate right by top six bits
	function automatic logic [63:0] gen_out(input logic [127:0] st);
		logic [63:0]  x;
		logic [127:0] xx;
		x  = st[127:64] ^ st[63:0];
		xx = {x, x} >> st[127:122];
		return xx[63:0];
	endfunction

	// 32 x 32 unsigned product
	function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return {32'd0, a} * {32'd0, b};
	endfunction

endpackage
`default_nettype wire

/* rtl/core/pcg_xor_sbox_word_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_xor_sbox_word_cipher
// Per-word cipher: pcg xsl-rr keys around a byte substitution.
// ----------------------------------------------------------------------------
// One request enters every cycle while no result waits at the output; each
// encrypt or decrypt request returns its word, and table loads take a pipeline
// slot and return nothing. The path is made of three generator steps, each a
// three-stage 32x32 multiply-add, plus a seed stage and three substitution
// stages. The whole pipeline holds when a result waits at the output. Tables
// must be loaded before words that use them; the eight byte lanes each keep a
// copy of both tables so all bytes are substituted in the same stage.
// ----------------------------------------------------------------------------
module pcg_xor_sbox_word_cipher (
	input  wire          clk,
	input  wire          arst_n,
	// configuration
	input  wire          cfg_we,
	input  wire          cfg_addr,
	input  wire [63:0]   cfg_data,
	// request stream
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire [143:0]  s_tdata,  // word_index, data_word, table_slot, table_byte
	input  wire [1:0]    s_tuser,  // func
	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata   // result_word
);
	import pxswc_pkg::*;

	logic         en;
	logic [63:0]  seed_low_q, seed_high_q;

	logic         v_s1;
	logic [127:0] st_s1;
	side_t        side_in, side_s1;

	logic         v_a, v_b, v_c;
	logic [127:0] st_a, st_b, st_c;
	side_t        side_a, side_b, side_b2, side_c;

	logic         v_s2, v_s3, v_s4;
	func_t        func_s2, func_s3, func_s4;
	logic [63:0]  w_s2, key1_s2, key2_s2;
	logic [7:0]   slot_s2, tbyte_s2;
	logic         tsel_s2;
	logic [63:0]  rd_s3, key1_s3, key2_s3;
	logic [63:0]  result_s4;
	logic         tab_wr;
	logic [63:0]  key2_c;
	logic         dec_c;

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= 64'd0;
			seed_high_q <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SEED_LOW:  seed_low_q  <= cfg_data;
				REG_SEED_HIGH: seed_high_q <= cfg_data;
				default:       seed_low_q  <= seed_low_q;
			endcase
		end
	end

	// unpack request
	always_comb begin
		side_in.func  = func_t'(s_tuser);
		side_in.idx   = s_tdata[63:0];
		side_in.data  = s_tdata[127:64];
		side_in.slot  = s_tdata[135:128];
		side_in.tbyte = s_tdata[143:136];
		side_in.key1  = 64'd0;
	end

	// first step from zero gives inc; add the seed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			st_s1   <= {63'd0, s_tdata[63:0], 1'b1} + {seed_high_q, seed_low_q};
		end
	end

	// three generator steps
	pxswc_lcg_step u_step_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_state(st_s1), .in_side(side_s1),
		.out_valid(v_a), .out_state(st_a), .out_side(side_a)
	);

	pxswc_lcg_step u_step_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_a), .in_state(st_a), .in_side(side_a),
		.out_valid(v_b), .out_state(st_b), .out_side(side_b)
	);

	// key1 from the third state
	always_comb begin
		side_b2      = side_b;
		side_b2.key1 = gen_out(st_b);
	end

	pxswc_lcg_step u_step_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_b), .in_state(st_b), .in_side(side_b2),
		.out_valid(v_c), .out_state(st_c), .out_side(side_c)
	);

	assign key2_c = gen_out(st_c);
	assign dec_c  = (side_c.func == FUNC_DECRYPT) || (side_c.func == FUNC_LOAD_INV);

	// key2 and the pre-substitution word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_c;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && ((func_s3 == FUNC_ENCRYPT) || (func_s3 == FUNC_DECRYPT));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2  <= side_c.func;
			tsel_s2  <= dec_c;
			w_s2     <= side_c.data ^ (dec_c ? key2_c : side_c.key1);
			key1_s2  <= side_c.key1;
			key2_s2  <= key2_c;
			slot_s2  <= side_c.slot;
			tbyte_s2 <= side_c.tbyte;
		end
	end

	assign tab_wr = en && v_s2 &&
		((func_s2 == FUNC_LOAD_FWD) || (func_s2 == FUNC_LOAD_INV));

	// substitution tables, one copy per byte lane, both tables per copy
	for (genvar g = 0; g < 8; g++) begin : g_lane
		logic [7:0] tab_mem [512];
		always_ff @(posedge clk) begin
			if (tab_wr) begin
				tab_mem[{tsel_s2, slot_s2}] <= tbyte_s2;
			end
			if (en) begin
				rd_s3[8*g +: 8] <= tab_mem[{tsel_s2, w_s2[8*g +: 8]}];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			key1_s3 <= key1_s2;
			key2_s3 <= key2_s2;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (en) begin
			func_s4   <= func_s3;
			result_s4 <= rd_s3 ^ ((func_s3 == FUNC_DECRYPT) ? key1_s3 : key2_s3);
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = result_s4;

	// only cipher requests reach the output
	a_out_cipher: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((func_s4 == FUNC_ENCRYPT) || (func_s4 == FUNC_DECRYPT)))
		else $error("load request reached output");

	// a held pipeline keeps its first stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1))
		else $error("stage 1 valid moved during hold");

	// a table load in the stage before the output gives no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && ((func_s3 == FUNC_LOAD_FWD) || (func_s3 == FUNC_LOAD_INV)))
		|=> !m_tvalid)
		else $error("table load produced a result");

	// table writes happen only while the pipeline moves
	a_wr_en: assert property (@(posedge clk) disable iff (!arst_n)
		tab_wr |-> (en && v_s2))
		else $error("table write while held");

endmodule
`default_nettype wire

/* rtl/core/pxswc_lcg_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxswc_lcg_step
// One generator step st * M + inc (mod 2^128) in three register stages:
// partial products, two partial sums, final add.
// ----------------------------------------------------------------------------
module pxswc_lcg_step (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire [127:0]          in_state,
	input  pxswc_pkg::side_t     in_side,
	output logic                 out_valid,
	output logic [127:0]         out_state,
	output pxswc_pkg::side_t     out_side
);
	import pxswc_pkg::*;

	logic [31:0] a0, a1, a2, a3;
	logic [31:0] m0, m1, m2, m3;

	logic        v_s1, v_s2, v_s3;
	side_t       side_s1, side_s2, side_s3;
	logic [63:0] p00_s1, p01_s1, p10_s1, p02_s1, p11_s1, p20_s1;
	logic [63:0] p03_s1, p12_s1, p21_s1, p30_s1;
	logic [127:0] lo_s2;
	logic [63:0]  hi_s2;
	logic [127:0] st_s3;
	logic [127:0] inc;
	logic [31:0]  col3;

	assign {a3, a2, a1, a0} = in_state;
	assign {m3, m2, m1, m0} = LCG_MULT;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// products of limbs that land below bit 128
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			p00_s1  <= mul32(a0, m0);
			p01_s1  <= mul32(a0, m1);
			p10_s1  <= mul32(a1, m0);
			p02_s1  <= mul32(a0, m2);
			p11_s1  <= mul32(a1, m1);
			p20_s1  <= mul32(a2, m0);
			p03_s1  <= mul32(a0, m3);
			p12_s1  <= mul32(a1, m2);
			p21_s1  <= mul32(a2, m1);
			p30_s1  <= mul32(a3, m0);
		end
	end

	// stream increment (index << 1) | 1
	assign inc  = {63'd0, side_s1.idx, 1'b1};
	assign col3 = p03_s1[31:0] + p12_s1[31:0] + p21_s1[31:0] + p30_s1[31:0];

	// low columns plus increment, high columns folded to 64 bits
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			lo_s2   <= {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0}
				+ {32'd0, p10_s1, 32'd0} + inc;
			hi_s2   <= p02_s1 + p11_s1 + p20_s1 + {col3, 32'd0};
		end
	end

	// final sum
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			st_s3   <= lo_s2 + {hi_s2, 64'd0};
		end
	end

	assign out_valid = v_s3;
	assign out_state = st_s3;
	assign out_side  = side_s3;

endmodule
`default_nettype wire

/* tb/tb_pcg_xor_sbox_word_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcg_xor_sbox_word_cipher
// Self-checking bench: loads substitution tables, streams encrypt and decrypt
// requests under several seed settings and idle patterns, and compares every
// returned word with a behavioral copy of the pcg keyed cipher.
// ----------------------------------------------------------------------------
module tb_pcg_xor_sbox_word_cipher;
	import pxswc_pkg::*;

	localparam logic [127:0] GEN_MUL = 128'h2360ED051FC65DA4_4385DF649FCCF645;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic          cfg_addr;
	logic [63:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [143:0]  s_tdata;
	logic [1:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [63:0]   m_tdata;

	pcg_xor_sbox_word_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// cipher state mirrored on the bench side
	logic [63:0]  mdl_seed_lo, mdl_seed_hi;
	logic [7:0]   mdl_fwd [256];
	logic [7:0]   mdl_inv [256];
	logic [63:0]  pending_words [$];
	int           errors;
	int           send_idle_pct, recv_stall_pct;

	// one request row of the directed table
	typedef struct {
		func_t       func;
		logic [63:0] idx;
		logic [63:0] data;
		logic [7:0]  slot;
		logic [7:0]  tbyte;
	} req_t;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// overall limit
	initial begin
		#40ms;
		$display("pcg_xor_sbox_word_cipher regression: fail");
		$finish;
	end

	// one pcg lcg step
	function automatic logic [127:0] lcg_step(input logic [127:0] st, input logic [127:0] inc);
		return st * GEN_MUL + inc;
	endfunction

	// xsl-rr output
	function automatic logic [63:0] xsl_rr(input logic [127:0] st);
		logic [63:0] x;
		int          r;
		x = st[127:64] ^ st[63:0];
		r = int'(st[127:122]);
		return (r == 0) ? x : ((x >> r) | (x << (64 - r)));
	endfunction

	// expected word for an encrypt or decrypt request
	function automatic logic [63:0] cipher_word(input func_t f, input logic [63:0] idx,
			input logic [63:0] data);
		logic [127:0] inc, st;
		logic [63:0]  key1, key2, w, r;
		inc = {63'd0, idx, 1'b1};
		st  = lcg_step(128'd0, inc);
		st  = st + {mdl_seed_hi, mdl_seed_lo};
		st  = lcg_step(st, inc);
		st  = lcg_step(st, inc);
		key1 = xsl_rr(st);
		st  = lcg_step(st, inc);
		key2 = xsl_rr(st);
		w = data ^ ((f == FUNC_ENCRYPT) ? key1 : key2);
		for (int k = 0; k < 8; k++)
			r[8*k +: 8] = (f == FUNC_ENCRYPT) ? mdl_fwd[w[8*k +: 8]] : mdl_inv[w[8*k +: 8]];
		return r ^ ((f == FUNC_ENCRYPT) ? key2 : key1);
	endfunction

	// drive one request and record what it should return; valid stays high
	// after the accept so the next request can follow in the very next cycle
	task automatic send_req(input req_t q, input logic [63:0] want, input bit typed);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		case (q.func)
			FUNC_LOAD_FWD: mdl_fwd[q.slot] = q.tbyte;
			FUNC_LOAD_INV: mdl_inv[q.slot] = q.tbyte;
			default: pending_words.push_back(typed ? want : cipher_word(q.func, q.idx, q.data));
		endcase
		s_tvalid <= 1'b1;
		s_tuser  <= q.func;
		s_tdata  <= {q.tbyte, q.slot, q.data, q.idx};
		do @(posedge clk); while (!s_tready);
	endtask

	// wait for every outstanding word, then let loads drain
	task automatic drain;
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] lo, input logic [63:0] hi);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_addr <= REG_SEED_LOW; cfg_data <= lo;
		@(posedge clk);
		cfg_addr <= REG_SEED_HIGH; cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_seed_lo = lo;
		mdl_seed_hi = hi;
	endtask

	// receiver: random stall and result compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_words.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $realtime, m_tdata);
					errors++;
				end else begin
					if (m_tdata !== pending_words[0]) begin
						$display("%0t result_word mismatch: expected %h, actual %h",
							$realtime, pending_words[0], m_tdata);
						errors++;
					end
					void'(pending_words.pop_front());
				end
			end
			m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// random word request, mostly full-width random indexes with some small ones
	function automatic req_t rand_word;
		req_t q;
		q.func  = $urandom_range(1) ? FUNC_ENCRYPT : FUNC_DECRYPT;
		q.idx   = {$urandom, $urandom};
		if ($urandom_range(3) == 0) q.idx = 64'($urandom_range(15));
		q.data  = {$urandom, $urandom};
		q.slot  = 8'($urandom);
		q.tbyte = 8'($urandom);
		return q;
	endfunction

	// stimulus
	initial begin
		req_t  dir_rows [$];
		req_t  q;
		int    phase;

		errors = 0; send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_addr = REG_SEED_LOW; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = FUNC_LOAD_FWD; m_tready = 1'b1;
		mdl_seed_lo = '0; mdl_seed_hi = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity tables so every entry is written
		for (int i = 0; i < 256; i++) begin
			send_req('{FUNC_LOAD_FWD, {$urandom, $urandom}, {$urandom, $urandom}, 8'(i), 8'(i)},
				64'd0, 1'b0);
			send_req('{FUNC_LOAD_INV, {$urandom, $urandom}, {$urandom, $urandom}, 8'(i), 8'(i)},
				64'd0, 1'b0);
		end

		// directed rows: with identity tables and zero seed at index 0,
		// encrypt and decrypt of a word are the same xor of both keys
		dir_rows = '{
			'{FUNC_ENCRYPT, 64'd0, 64'd0, 8'd0, 8'd0},
			'{FUNC_DECRYPT, 64'd0, 64'd0, 8'hFF, 8'hFF},
			'{FUNC_ENCRYPT, '1, '1, 8'd0, 8'd0},
			'{FUNC_DECRYPT, '1, '1, 8'd0, 8'd0},
			'{FUNC_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 8'd0, 8'd0},
			'{FUNC_DECRYPT, 64'd1, 64'hFEDC_BA98_7654_3210, 8'd0, 8'd0},
			'{FUNC_LOAD_FWD, '1, '1, 8'hFF, 8'h00},
			'{FUNC_LOAD_FWD, '1, '1, 8'h00, 8'hFF},
			'{FUNC_LOAD_INV, 64'd0, 64'd0, 8'hFF, 8'h00},
			'{FUNC_LOAD_INV, 64'd0, 64'd0, 8'h00, 8'hFF},
			'{FUNC_ENCRYPT, 64'd2, 64'd0, 8'd0, 8'd0},
			'{FUNC_DECRYPT, 64'd3, '1, 8'd0, 8'd0}
		};
		foreach (dir_rows[i]) send_req(dir_rows[i], 64'd0, 1'b0);
		drain();

		// seed extremes and random seeds, with varied idle and stall patterns
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_seed('1, '1);
				1: write_seed('1, 64'd0);
				2: write_seed(64'd0, '1);
				default: write_seed({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				3: begin send_idle_pct = 12; recv_stall_pct = 12; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			// fresh random entries (tables no longer inverse of each other)
			if (phase == 3) begin
				for (int i = 0; i < 16; i++) begin
					send_req('{FUNC_LOAD_FWD, 64'd0, 64'd0, 8'($urandom), 8'($urandom)},
						64'd0, 1'b0);
					send_req('{FUNC_LOAD_INV, 64'd0, 64'd0, 8'($urandom), 8'($urandom)},
						64'd0, 1'b0);
				end
			end
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(9) == 0) begin
					q = rand_word();
					q.func = $urandom_range(1) ? FUNC_LOAD_FWD : FUNC_LOAD_INV;
					send_req(q, 64'd0, 1'b0);
				end else begin
					send_req(rand_word(), 64'd0, 1'b0);
				end
				// sender holds off until every outstanding word has returned
				if (n == 75) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending_words.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("pcg_xor_sbox_word_cipher regression: pass");
		else
			$display("pcg_xor_sbox_word_cipher regression: fail");
		$finish;
	end

endmodule
